FILE: rtl/assert_macros.svh
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BTW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define BTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/btw_pkg.sv
// shared constants and control types for the bus timer and watchdog block
`timescale 1ns / 1ps

package btw_pkg;

  localparam int unsigned PULSE_CYCLES = 8;
  localparam int unsigned PULSE_W      = 4;
  localparam int unsigned TMR_REM_W    = 17;
  localparam int unsigned TMR_PER_W    = 16;
  localparam int unsigned DOG_W        = 24;

  localparam logic [7:0] REG_PAGE     = 8'hDF;
  localparam logic [7:0] OFF_IRQ_LAST = 8'h03;
  localparam logic [7:0] OFF_NMI_LAST = 8'h07;
  localparam logic [7:0] OFF_DOG_LAST = 8'h0B;
  localparam logic [7:0] FLAG_BYTE    = 8'h80;

  // watchdog register select, offset bits 1..0
  localparam logic [1:0] DOG_STOP  = 2'd0;
  localparam logic [1:0] DOG_BYTE0 = 2'd1;
  localparam logic [1:0] DOG_BYTE1 = 2'd2;
  localparam logic [1:0] DOG_START = 2'd3;

  typedef struct packed {
    logic step;
    logic reboot;
    logic clear;
    logic rd_clr;
    logic wr;
    logic wr_hi;
    logic one_shot;
  } tmr_ctl_t;

  typedef struct packed {
    logic       step;
    logic       reboot;
    logic       clear;
    logic       wr;
    logic [1:0] sel;
  } dog_ctl_t;

endpackage

FILE: rtl/btw_in_if.sv
// input channel: one bus cycle per item
`timescale 1ns / 1ps

interface btw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic        is_read;
  logic [7:0]  write_byte;
  logic        reset_n;
  logic        reboot;

  modport source (output valid, bus_address, is_read, write_byte, reset_n, reboot,
                  input ready);
  modport sink   (input valid, bus_address, is_read, write_byte, reset_n, reboot,
                  output ready);
endinterface

FILE: rtl/btw_out_if.sv
// output channel: bus read data and line levels per item
`timescale 1ns / 1ps

interface btw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       drive_bus;
  logic       irq_n;
  logic       nmi_n;
  logic       ready_res;
  logic       reset_out_n;

  modport source (output valid, read_byte, drive_bus, irq_n, nmi_n, ready_res,
                  reset_out_n, input ready);
  modport sink   (input valid, read_byte, drive_bus, irq_n, nmi_n, ready_res,
                  reset_out_n, output ready);
endinterface

FILE: rtl/bus_timer_watchdog_io.sv
// top level: bus cycle decode, timers, watchdog and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one CPU bus cycle per item and returns one result per item: the read
// byte for the page 0xDF status registers plus the irq, nmi, rdy and
// reset-out line levels after that cycle. A new item is accepted every clock
// cycle unless the output stalls; it passes the input register, then the
// result register. All timer, watchdog and pulse state updates as an item
// moves between those two registers, so each item sees the state that the
// previous item left. PulseCycles (1..15) sets both the reset-out pulse
// length and the early line pull-down window of the timers.
module bus_timer_watchdog_io #(
  parameter int unsigned PulseCycles = btw_pkg::PULSE_CYCLES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  btw_in_if.sink     in_i,
  btw_out_if.source  out_o
);

  logic        s1_valid_q;
  logic [15:0] addr_q;
  logic        is_read_q;
  logic [7:0]  wbyte_q;
  logic        reset_n_q;
  logic        reboot_q;
  logic        advance;
  logic        in_take;

  logic        out_valid_q;
  logic [7:0]  read_byte_q, read_byte_d;
  logic        drive_q, drive_d;
  logic        irq_n_q, nmi_n_q, rdy_q, rst_out_q;

  logic        page_hit;
  logic [7:0]  off;
  logic        rd_irq, rd_nmi, rd_dog, wr_tmr, wr_dog;

  btw_pkg::tmr_ctl_t irq_ctl, nmi_ctl;
  btw_pkg::dog_ctl_t dog_ctl;
  logic irq_flag, irq_level, nmi_flag, nmi_level;
  logic dog_run, dog_ready, dog_rst_out_n;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      addr_q    <= in_i.bus_address;
      is_read_q <= in_i.is_read;
      wbyte_q   <= in_i.write_byte;
      reset_n_q <= in_i.reset_n;
      reboot_q  <= in_i.reboot;
    end
  end

  // register decode for the bus cycle in the input register
  always_comb begin
    page_hit = (addr_q[15:8] == btw_pkg::REG_PAGE);
    off      = addr_q[7:0];
    rd_irq   = page_hit && is_read_q && (off <= btw_pkg::OFF_IRQ_LAST);
    rd_nmi   = page_hit && is_read_q && (off > btw_pkg::OFF_IRQ_LAST)
               && (off <= btw_pkg::OFF_NMI_LAST);
    rd_dog   = page_hit && is_read_q && (off > btw_pkg::OFF_NMI_LAST)
               && (off <= btw_pkg::OFF_DOG_LAST);
    wr_tmr   = page_hit && !is_read_q && (off <= btw_pkg::OFF_NMI_LAST);
    wr_dog   = page_hit && !is_read_q && (off > btw_pkg::OFF_NMI_LAST)
               && (off <= btw_pkg::OFF_DOG_LAST);

    irq_ctl.step     = advance;
    irq_ctl.reboot   = reboot_q;
    irq_ctl.clear    = !reset_n_q;
    irq_ctl.rd_clr   = rd_irq;
    irq_ctl.wr       = wr_tmr && !off[2];
    irq_ctl.wr_hi    = off[0];
    irq_ctl.one_shot = off[1];

    nmi_ctl          = irq_ctl;
    nmi_ctl.rd_clr   = rd_nmi;
    nmi_ctl.wr       = wr_tmr && off[2];

    dog_ctl.step   = advance;
    dog_ctl.reboot = reboot_q;
    dog_ctl.clear  = !reset_n_q;
    dog_ctl.wr     = wr_dog;
    dog_ctl.sel    = off[1:0];
  end

  btw_timer #(.PulseCycles(PulseCycles)) u_irq_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (irq_ctl),
    .wr_byte_i (wbyte_q),
    .flag_o    (irq_flag),
    .level_o   (irq_level)
  );

  btw_timer #(.PulseCycles(PulseCycles)) u_nmi_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (nmi_ctl),
    .wr_byte_i (wbyte_q),
    .flag_o    (nmi_flag),
    .level_o   (nmi_level)
  );

  btw_dog #(.PulseCycles(PulseCycles)) u_dog (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (dog_ctl),
    .wr_byte_i     (wbyte_q),
    .running_o     (dog_run),
    .ready_o       (dog_ready),
    .reset_out_n_o (dog_rst_out_n)
  );

  always_comb begin
    read_byte_d = 8'h00;
    drive_d     = rd_irq || rd_nmi || rd_dog;
    priority if (rd_irq) begin
      read_byte_d = irq_flag ? btw_pkg::FLAG_BYTE : 8'h00;
    end else if (rd_nmi) begin
      read_byte_d = nmi_flag ? btw_pkg::FLAG_BYTE : 8'h00;
    end else if (rd_dog) begin
      read_byte_d = dog_run ? btw_pkg::FLAG_BYTE : 8'h00;
    end else begin
      read_byte_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      read_byte_q <= read_byte_d;
      drive_q     <= drive_d;
      irq_n_q     <= irq_level;
      nmi_n_q     <= nmi_level;
      rdy_q       <= dog_ready;
      rst_out_q   <= dog_rst_out_n;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_byte   = read_byte_q;
  assign out_o.drive_bus   = drive_q;
  assign out_o.irq_n       = irq_n_q;
  assign out_o.nmi_n       = nmi_n_q;
  assign out_o.ready_res   = rdy_q;
  assign out_o.reset_out_n = rst_out_q;

  `BTW_ASSERT_NOW(a_idle_bus_zero, out_valid_q && !drive_q, read_byte_q == 8'h00)
  `BTW_ASSERT_NEXT(a_advance_fills, advance, out_valid_q)
  `BTW_ASSERT_NOW(a_empty_takes, !s1_valid_q, in_i.ready)
  `BTW_ASSERT_NOW(a_one_read_src, s1_valid_q, $onehot0({rd_irq, rd_nmi, rd_dog, wr_tmr, wr_dog}))

endmodule

FILE: rtl/btw_timer.sv
// one 16-bit interrupt timer with flag and line level
`timescale 1ns / 1ps

module btw_timer #(
  parameter int unsigned PulseCycles = btw_pkg::PULSE_CYCLES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btw_pkg::tmr_ctl_t  ctl_i,
  input  logic [7:0]         wr_byte_i,
  output logic               flag_o,
  output logic               level_o
);

  localparam logic [btw_pkg::TMR_REM_W-1:0] PulseRem = btw_pkg::TMR_REM_W'(PulseCycles);

  logic [btw_pkg::TMR_REM_W-1:0] rem_q, rem_d, rem0, rem1;
  logic [btw_pkg::TMR_PER_W-1:0] per_q, per_d, per0, per_new;
  logic                          flag_q, flag_d, flag0, flag1;
  logic                          level_q, level_d, level0;

  always_comb begin
    level0 = ctl_i.reboot ? 1'b1 : level_q;
    rem0   = ctl_i.clear ? '0 : rem_q;
    per0   = ctl_i.clear ? '0 : per_q;
    flag0  = ctl_i.clear ? 1'b0 : flag_q;

    rem1    = rem0;
    flag1   = flag0;
    level_d = level0;
    if (rem0 != '0) begin
      rem1 = rem0 - 1'b1;
      if (rem1 < PulseRem) level_d = 1'b0;
      if (rem1 == '0) begin
        rem1  = {1'b0, per0};
        flag1 = 1'b1;
      end
    end else begin
      level_d = 1'b1;
    end

    flag_o  = flag1;
    rem_d   = rem1;
    per_d   = per0;
    flag_d  = ctl_i.rd_clr ? 1'b0 : flag1;
    per_new = per0 | {wr_byte_i, 8'h00};
    if (ctl_i.wr) begin
      if (ctl_i.wr_hi) begin
        rem_d = {1'b0, per_new} + PulseRem;
        per_d = ctl_i.one_shot ? '0 : per_new;
      end else begin
        flag_d = 1'b0;
        per_d  = {8'h00, wr_byte_i};
        rem_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      per_q   <= '0;
      flag_q  <= 1'b0;
      level_q <= 1'b1;
    end else if (ctl_i.step) begin
      rem_q   <= rem_d;
      per_q   <= per_d;
      flag_q  <= flag_d;
      level_q <= level_d;
    end
  end

  assign level_o = level_d;

endmodule

FILE: rtl/btw_dog.sv
// 24-bit watchdog with rdy level and reset-out pulse counter
`timescale 1ns / 1ps

module btw_dog #(
  parameter int unsigned PulseCycles = btw_pkg::PULSE_CYCLES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btw_pkg::dog_ctl_t  ctl_i,
  input  logic [7:0]         wr_byte_i,
  output logic               running_o,
  output logic               ready_o,
  output logic               reset_out_n_o
);

  localparam logic [btw_pkg::PULSE_W-1:0] PulseInit = btw_pkg::PULSE_W'(PulseCycles);

  logic [btw_pkg::DOG_W-1:0]   rem_q, rem_d, rem0, rem1;
  logic [btw_pkg::DOG_W-1:0]   per_q, per_d, per0, per_or;
  logic                        rdy_q, rdy_d;
  logic [btw_pkg::PULSE_W-1:0] pulse_q, pulse_d, pulse0;

  always_comb begin
    rdy_d  = ctl_i.reboot ? 1'b1 : rdy_q;
    pulse0 = ctl_i.reboot ? PulseInit : pulse_q;
    rem0   = ctl_i.clear ? '0 : rem_q;
    per0   = ctl_i.clear ? '0 : per_q;

    rem1 = rem0;
    if (rem0 != '0) begin
      rem1 = rem0 - 1'b1;
      if (rem1 == '0) rdy_d = 1'b0;
    end

    if (pulse0 != '0) begin
      pulse_d       = pulse0 - 1'b1;
      reset_out_n_o = 1'b0;
    end else begin
      pulse_d       = pulse0;
      reset_out_n_o = 1'b1;
    end

    running_o = (rem1 != '0);

    unique case (ctl_i.sel)
      btw_pkg::DOG_BYTE0: per_or = per0 | {16'h0000, wr_byte_i};
      btw_pkg::DOG_BYTE1: per_or = per0 | {8'h00, wr_byte_i, 8'h00};
      btw_pkg::DOG_START: per_or = per0 | {wr_byte_i, 16'h0000};
      default:            per_or = per0;
    endcase

    rem_d = rem1;
    per_d = per0;
    if (ctl_i.wr) begin
      if (ctl_i.sel == btw_pkg::DOG_STOP) begin
        rem_d = '0;
        per_d = '0;
      end else if (rem1 != '0) begin
        rem_d = per0;
      end else begin
        per_d = per_or;
        if (ctl_i.sel == btw_pkg::DOG_START) rem_d = per_or;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      per_q   <= '0;
      rdy_q   <= 1'b1;
      pulse_q <= PulseInit;
    end else if (ctl_i.step) begin
      rem_q   <= rem_d;
      per_q   <= per_d;
      rdy_q   <= rdy_d;
      pulse_q <= pulse_d;
    end
  end

  assign ready_o = rdy_d;

endmodule

FILE: verif/tb_bus_timer_watchdog_io.sv
// testbench for the bus timer, watchdog and status register block
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] addr;
  logic        rd;
  logic [7:0]  wbyte;
  logic        rst_n;
  logic        reboot;
} bus_cycle_t;

typedef struct packed {
  logic [7:0] read_byte;
  logic       drive_bus;
  logic       irq_n;
  logic       nmi_n;
  logic       ready_res;
  logic       reset_out_n;
} line_state_t;

typedef struct packed {
  logic [btw_pkg::TMR_REM_W-1:0] rem;
  logic [btw_pkg::TMR_PER_W-1:0] period;
  logic                          flag;
  logic                          level;
} tmr_state_t;

localparam int IRQ_TMR = 0;
localparam int NMI_TMR = 1;

// timer register offset bits
localparam int SEL_HI_BIT       = 0;
localparam int SEL_ONE_SHOT_BIT = 1;
localparam int SEL_NMI_BIT      = 2;

localparam logic [7:0] OFF_IRQ_LO    = 8'h00;
localparam logic [7:0] OFF_IRQ_HI    = 8'h01;
localparam logic [7:0] OFF_IRQ_OS_LO = 8'h02;
localparam logic [7:0] OFF_IRQ_OS_HI = 8'h03;
localparam logic [7:0] OFF_NMI_LO    = 8'h04;
localparam logic [7:0] OFF_NMI_OS_LO = 8'h06;
localparam logic [7:0] OFF_NMI_OS_HI = 8'h07;
localparam logic [7:0] OFF_DOG_BASE  = 8'h08;

class bus_cycle_scoreboard;
  tmr_state_t                  tmr[2];
  logic [btw_pkg::DOG_W-1:0]   dog_left;
  logic [btw_pkg::DOG_W-1:0]   dog_period;
  logic                        rdy_level;
  logic [btw_pkg::PULSE_W-1:0] pulse_left;
  line_state_t                 expected_lines[$];
  int unsigned                 results_seen;
  int unsigned                 errors;

  function new();
    foreach (tmr[i]) tmr[i] = '{rem: '0, period: '0, flag: 1'b0, level: 1'b1};
    dog_left     = '0;
    dog_period   = '0;
    rdy_level    = 1'b1;
    pulse_left   = btw_pkg::PULSE_W'(btw_pkg::PULSE_CYCLES);
    results_seen = 0;
    errors       = 0;
  endfunction

  function void tick_timer(inout tmr_state_t t);
    if (t.rem != '0) begin
      t.rem = t.rem - 1'b1;
      if (t.rem < btw_pkg::TMR_REM_W'(btw_pkg::PULSE_CYCLES)) t.level = 1'b0;
      if (t.rem == '0) begin
        t.rem  = {1'b0, t.period};
        t.flag = 1'b1;
      end
    end else begin
      t.level = 1'b1;
    end
  endfunction

  function void load_timer(input logic [2:0] sel, input logic [7:0] value,
                           inout tmr_state_t t);
    if (sel[SEL_HI_BIT]) begin
      t.period[15:8] = t.period[15:8] | value;
      t.rem = {1'b0, t.period} + btw_pkg::TMR_REM_W'(btw_pkg::PULSE_CYCLES);
      if (sel[SEL_ONE_SHOT_BIT]) t.period = '0;
    end else begin
      t.flag   = 1'b0;
      t.period = {8'h00, value};
      t.rem    = '0;
    end
  endfunction

  function void load_dog(input logic [1:0] sel, input logic [7:0] value);
    if (sel == btw_pkg::DOG_STOP) begin
      dog_left   = '0;
      dog_period = '0;
    end else if (dog_left != '0) begin
      // a running watchdog only restarts
      dog_left = dog_period;
    end else begin
      case (sel)
        btw_pkg::DOG_BYTE0: dog_period[7:0]   = dog_period[7:0] | value;
        btw_pkg::DOG_BYTE1: dog_period[15:8]  = dog_period[15:8] | value;
        default:            dog_period[23:16] = dog_period[23:16] | value;
      endcase
      if (sel == btw_pkg::DOG_START) dog_left = dog_period;
    end
  endfunction

  function line_state_t advance_bus_cycle(bus_cycle_t c);
    line_state_t r;
    logic [7:0]  off;
    r   = '0;
    off = c.addr[7:0];
    if (c.reboot) begin
      rdy_level          = 1'b1;
      tmr[IRQ_TMR].level = 1'b1;
      tmr[NMI_TMR].level = 1'b1;
      pulse_left         = btw_pkg::PULSE_W'(btw_pkg::PULSE_CYCLES);
    end
    if (!c.rst_n) begin
      foreach (tmr[i]) begin
        tmr[i].rem    = '0;
        tmr[i].period = '0;
        tmr[i].flag   = 1'b0;
      end
      dog_left   = '0;
      dog_period = '0;
    end
    if (dog_left != '0) begin
      dog_left = dog_left - 1'b1;
      if (dog_left == '0) rdy_level = 1'b0;
    end
    if (pulse_left != '0) begin
      pulse_left    = pulse_left - 1'b1;
      r.reset_out_n = 1'b0;
    end else begin
      r.reset_out_n = 1'b1;
    end
    tick_timer(tmr[NMI_TMR]);
    tick_timer(tmr[IRQ_TMR]);
    if (c.addr[15:8] == btw_pkg::REG_PAGE) begin
      if (c.rd) begin
        if (off <= btw_pkg::OFF_IRQ_LAST) begin
          r.read_byte       = tmr[IRQ_TMR].flag ? btw_pkg::FLAG_BYTE : 8'h00;
          tmr[IRQ_TMR].flag = 1'b0;
          r.drive_bus       = 1'b1;
        end else if (off <= btw_pkg::OFF_NMI_LAST) begin
          r.read_byte       = tmr[NMI_TMR].flag ? btw_pkg::FLAG_BYTE : 8'h00;
          tmr[NMI_TMR].flag = 1'b0;
          r.drive_bus       = 1'b1;
        end else if (off <= btw_pkg::OFF_DOG_LAST) begin
          r.read_byte = (dog_left != '0) ? btw_pkg::FLAG_BYTE : 8'h00;
          r.drive_bus = 1'b1;
        end
      end else if (off <= btw_pkg::OFF_NMI_LAST) begin
        load_timer(off[2:0], c.wbyte, tmr[off[SEL_NMI_BIT]]);
      end else if (off <= btw_pkg::OFF_DOG_LAST) begin
        load_dog(off[1:0], c.wbyte);
      end
    end
    r.irq_n     = tmr[IRQ_TMR].level;
    r.nmi_n     = tmr[NMI_TMR].level;
    r.ready_res = rdy_level;
    return r;
  endfunction

  function void note_input(bus_cycle_t c);
    expected_lines.push_back(advance_bus_cycle(c));
  endfunction

  function int pending();
    return expected_lines.size();
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check(line_state_t got);
    line_state_t want;
    if (expected_lines.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding", results_seen));
    end else begin
      want = expected_lines.pop_front();
      if (got.read_byte !== want.read_byte)
        report($sformatf("result %0d read_byte expected %02h got %02h",
                         results_seen, want.read_byte, got.read_byte));
      if (got.drive_bus !== want.drive_bus)
        report($sformatf("result %0d drive_bus expected %b got %b",
                         results_seen, want.drive_bus, got.drive_bus));
      if (got.irq_n !== want.irq_n)
        report($sformatf("result %0d irq_n expected %b got %b",
                         results_seen, want.irq_n, got.irq_n));
      if (got.nmi_n !== want.nmi_n)
        report($sformatf("result %0d nmi_n expected %b got %b",
                         results_seen, want.nmi_n, got.nmi_n));
      if (got.ready_res !== want.ready_res)
        report($sformatf("result %0d ready_res expected %b got %b",
                         results_seen, want.ready_res, got.ready_res));
      if (got.reset_out_n !== want.reset_out_n)
        report($sformatf("result %0d reset_out_n expected %b got %b",
                         results_seen, want.reset_out_n, got.reset_out_n));
    end
    results_seen++;
  endtask
endclass

module tb_bus_timer_watchdog_io;

  localparam int ITEM_TARGET = 1350;

  typedef enum {RX_ALWAYS, RX_COIN, RX_PHASE, RX_STALLS} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  btw_in_if  in_if();
  btw_out_if out_if();

  bus_cycle_scoreboard sb;
  int          items_sent = 0;
  int          burst_left = 0;
  line_state_t seen_line;

  bus_timer_watchdog_io dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one bus cycle; gaps fall between bursts of random length
  task automatic put_cycle(input logic [15:0] addr, input logic rd,
                           input logic [7:0] wb, input logic rst_n,
                           input logic reboot);
    bus_cycle_t c;
    int         gap;
    c = '{addr: addr, rd: rd, wbyte: wb, rst_n: rst_n, reboot: reboot};
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.bus_address <= addr;
    in_if.is_read     <= rd;
    in_if.write_byte  <= wb;
    in_if.reset_n     <= rst_n;
    in_if.reboot      <= reboot;
    // handshake levels are stable from the falling edge to the next rising edge
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    sb.note_input(c);
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [7:0] off, input logic [7:0] wb);
    put_cycle({btw_pkg::REG_PAGE, off}, 1'b0, wb, 1'b1, 1'b0);
  endtask

  task automatic reg_read(input logic [7:0] off);
    put_cycle({btw_pkg::REG_PAGE, off}, 1'b1, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  // bus cycle that misses the register page
  task automatic idle_cycle();
    logic [15:0] addr;
    addr = 16'($urandom_range(0, 16'hFFFF));
    if (addr[15:8] == btw_pkg::REG_PAGE) addr[8] = ~addr[8];
    put_cycle(addr, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    burst_left = 0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_line = '{read_byte: out_if.read_byte, drive_bus: out_if.drive_bus,
                    irq_n: out_if.irq_n, nmi_n: out_if.nmi_n,
                    ready_res: out_if.ready_res, reset_out_n: out_if.reset_out_n};
      sb.check(seen_line);
    end
  end

  // receiver stall pattern, switching between randomly picked modes
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       stall_left;
    int       phase;
    logic     take;
    mode       = RX_ALWAYS;
    mode_left  = 0;
    stall_left = 0;
    phase      = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      phase++;
      case (mode)
        RX_ALWAYS: take = 1'b1;
        RX_COIN:   take = 1'($urandom_range(0, 1));
        RX_PHASE:  take = (phase % 4) == 0;
        default: begin
          if (stall_left > 0) begin
            take = 1'b0;
            stall_left--;
          end else begin
            take = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
          end
        end
      endcase
      out_if.ready <= take;
    end
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [15:0] addr;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  toff;
    int          pick;
    int          n;
    int          next_drain;
    sb = new();
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.bus_address <= '0;
    in_if.is_read     <= 1'b0;
    in_if.write_byte  <= '0;
    in_if.reset_n     <= 1'b1;
    in_if.reboot      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: timers, zero-period starts, watchdog, decode edges
    reg_read(OFF_IRQ_LO);
    reg_write(OFF_IRQ_LO, 8'h03);
    reg_write(OFF_IRQ_HI, 8'h00);
    reg_write(OFF_NMI_OS_LO, 8'h00);
    reg_write(OFF_NMI_OS_HI, 8'h00);
    reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_START}, 8'h00);
    reg_read({OFF_DOG_BASE[7:2], btw_pkg::DOG_START});
    reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_BYTE0}, 8'h06);
    reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_START}, 8'h00);
    reg_read({OFF_DOG_BASE[7:2], btw_pkg::DOG_STOP});
    put_cycle(16'hFFFF, 1'b0, 8'hFF, 1'b1, 1'b0);
    put_cycle(16'h0000, 1'b1, 8'h00, 1'b1, 1'b0);
    reg_read(btw_pkg::OFF_DOG_LAST + 8'h01);
    reg_read(8'hFF);
    put_cycle({btw_pkg::REG_PAGE - 8'h01, OFF_IRQ_OS_HI}, 1'b1, 8'h00, 1'b1, 1'b0);
    reg_read(OFF_IRQ_OS_HI);
    reg_read(OFF_NMI_LO);
    reg_read(OFF_NMI_OS_HI);
    reg_read(btw_pkg::OFF_DOG_LAST);
    reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_BYTE1}, 8'hFF);
    reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_STOP}, 8'hFF);
    // reboot together with reset on a flag read
    put_cycle({btw_pkg::REG_PAGE, OFF_IRQ_LO}, 1'b1, 8'hFF, 1'b0, 1'b1);
    reg_write(OFF_IRQ_OS_LO, 8'hFF);
    reg_write(OFF_IRQ_OS_HI, 8'hFF);
    reg_write(OFF_IRQ_LO, 8'h00);
    wait_for_results();

    next_drain = items_sent + 400;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_drain) begin
        wait_for_results();
        next_drain = items_sent + 400;
      end
      pick = $urandom_range(0, 99);
      addr = 16'($urandom_range(0, 16'hFFFF));
      if (pick < 35) begin
        // arm a timer, then let it run with some flag reads
        toff = {5'd0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0};
        lo = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 24));
        n = $urandom_range(0, 99);
        hi = (n < 80) ? 8'h00 : (n < 95) ? 8'($urandom_range(0, 2))
                                         : 8'($urandom_range(0, 255));
        reg_write(toff, lo);
        reg_write(toff | 8'h01, hi);
        n = $urandom_range(0, 30);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0)
            reg_read(8'($urandom_range(0, btw_pkg::OFF_NMI_LAST)));
          else idle_cycle();
        end
      end else if (pick < 55) begin
        // set up the watchdog, kick it now and then, maybe let it expire
        reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_STOP}, 8'($urandom_range(0, 255)));
        reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_BYTE0},
                  ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(1, 30)));
        reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_BYTE1},
                  ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
        reg_write({OFF_DOG_BASE[7:2], btw_pkg::DOG_START},
                  ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
        n = $urandom_range(0, 45);
        repeat (n) begin
          pick = $urandom_range(0, 99);
          if (pick < 10)
            reg_write({OFF_DOG_BASE[7:2], 2'($urandom_range(1, 3))},
                      8'($urandom_range(0, 255)));
          else if (pick < 25)
            reg_read({OFF_DOG_BASE[7:2], 2'($urandom_range(0, 3))});
          else
            idle_cycle();
        end
        if ($urandom_range(0, 1) == 1)
          put_cycle(addr, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'b1, 1'b1);
      end else if (pick < 70) begin
        // anywhere in the register page, unused offsets included
        put_cycle({btw_pkg::REG_PAGE, 8'($urandom_range(0, 255))},
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else if (pick < 85) begin
        put_cycle(addr, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 19) != 0, $urandom_range(0, 19) == 0);
      end else if (pick < 93) begin
        put_cycle(addr, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 3) != 0, 1'b1);
      end else begin
        put_cycle(addr, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'b0, 1'($urandom_range(0, 1)));
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
